>>> hdl/dats_pkg.sv
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared sizes, command and status codes, states and helper functions.
// ----------------------------------------------------------------------------
package dats_pkg;

  localparam int TASKS       = 256;
  localparam int ID_W        = 8;
  localparam int PRIORITIES  = 3;
  localparam int WORKER_SETS = 4;
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_QUEUES  = PRIORITIES * (WORKER_SETS + 1);
  localparam int Q_W         = $clog2(NUM_QUEUES);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = QPTR_W + 1;
  localparam int JC_W        = 9;
  localparam int GRP_SIZE    = 8;
  localparam int GRP_BIT_W   = $clog2(GRP_SIZE);
  localparam int NUM_GRPS    = TASKS / GRP_SIZE;
  localparam int GRP_W       = $clog2(NUM_GRPS);
  localparam int STEP_W      = 3;

  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_END   = 3'd1;
  localparam logic [2:0] CMD_REQ   = 3'd2;
  localparam logic [2:0] CMD_DONE  = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_QFULL    = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] dep;
    logic [ID_W-1:0] par;
    logic [1:0]      pri;
    logic [2:0]      aff;
  } task_attr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FGRP, S_FBIT, S_BPRD, S_BPWR, S_RDT, S_ENDU,
    S_DONEP, S_DNRD, S_DNWR, S_QSEL, S_QPOP, S_QCHK, S_OUT
  } state_t;

  function automatic logic [1:0] sat_pri(input logic [1:0] p);
    if (32'(p) >= PRIORITIES) begin
      sat_pri = 2'(PRIORITIES - 1);
    end else begin
      sat_pri = p;
    end
  endfunction

  // Global FIFO p is index p, FIFO p of worker set s is PRIORITIES*(s+1)+p.
  function automatic logic [Q_W-1:0] queue_of(input logic [1:0] p, input logic [2:0] a);
    logic [1:0] ps;
    ps = sat_pri(p);
    if (a == 3'd0 || 32'(a) > WORKER_SETS) begin
      queue_of = Q_W'(ps);
    end else begin
      queue_of = Q_W'(PRIORITIES * 32'(a) + 32'(ps));
    end
  endfunction

endpackage

>>> hdl/dependency_aware_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Dependency-aware task scheduler
// Task pool with job counts, priority FIFOs per worker set and a global set.
// ----------------------------------------------------------------------------
// Query, unknown commands and end or done of a free id load the result directly;
// begin and done may add a parent update; a request visits up to six FIFOs, each
// found empty, with a dropped head, or with a popped and checked head.
// Throughput: one transaction at a time; the sequencer returns to idle as it loads
// the result, and a result held by out_tready delays the next load.
// Reset (synchronous, rst_n low) frees all ids and empties all FIFOs at once.
module dependency_aware_task_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // task_ref[7:0], priority_level[9:8], depend_ref[17:10], parent_ref[25:18],
  // affinity[28:26], worker_index[30:29]
  input  logic [31:0] in_tdata,
  // command[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_id[7:0], is_done[8], status[10:9], open_count[18:11]
  output logic [23:0] out_tdata
);

  localparam int ID_W   = dats_pkg::ID_W;
  localparam int Q_W    = dats_pkg::Q_W;
  localparam int QP_W   = dats_pkg::QPTR_W;
  localparam int QF_W   = dats_pkg::QFILL_W;
  localparam int JC_W   = dats_pkg::JC_W;
  localparam int NQ     = dats_pkg::NUM_QUEUES;
  localparam int TASKS  = dats_pkg::TASKS;
  localparam int GS     = dats_pkg::GRP_SIZE;
  localparam int NG     = dats_pkg::NUM_GRPS;
  localparam int GRP_W  = dats_pkg::GRP_W;
  localparam int GB_W   = dats_pkg::GRP_BIT_W;
  localparam int STEP_W = dats_pkg::STEP_W;
  localparam int PRIO   = dats_pkg::PRIORITIES;

  dats_pkg::state_t state_r, state_nxt;

  logic [2:0]       cmd_r, cmd_nxt;
  logic [ID_W-1:0]  ref_r, ref_nxt, dep_r, dep_nxt, par_r, par_nxt;
  logic [1:0]       pri_r, pri_nxt, wrk_r, wrk_nxt;
  logic [2:0]       aff_r, aff_nxt;
  logic [TASKS-1:0] used_r, used_nxt;
  logic [ID_W-1:0]  cnt_r, cnt_nxt;
  logic [QP_W-1:0]  head_r [NQ];
  logic [QF_W-1:0]  fill_r [NQ];
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ID_W-1:0]  rid_r, rid_nxt;
  logic             done_r, done_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic             out_tvalid_r;
  logic [23:0]      out_tdata_r;

  // Memories and their registered read data
  logic [JC_W-1:0]         jc_mem   [TASKS];
  dats_pkg::task_attr_t    attr_mem [TASKS];
  logic [ID_W-1:0]         st_mem   [NQ * dats_pkg::QUEUE_DEPTH];
  logic [JC_W-1:0]         jc_q;
  dats_pkg::task_attr_t    attr_q;
  logic [ID_W-1:0]         st_q;

  logic                 jc_we, jc_re, attr_we, attr_re, st_we, st_re;
  logic [ID_W-1:0]      jc_waddr, jc_raddr, attr_waddr, attr_raddr;
  logic [JC_W-1:0]      jc_wdata;
  dats_pkg::task_attr_t attr_wdata;
  logic [Q_W+QP_W-1:0]  st_waddr, st_raddr;
  logic [ID_W-1:0]      st_wdata;
  logic                 head_we, fill_we;
  logic [QP_W-1:0]      head_wdata;
  logic [QF_W-1:0]      fill_wdata;

  // Free id search and queue selection
  logic [NG-1:0]    grp_full;
  logic [GRP_W-1:0] grp_sel;
  logic             grp_any;
  logic [GS-1:0]    grp_bits;
  logic [GB_W-1:0]  bit_sel;
  logic             bit_any;
  logic             scan_skip;
  logic [Q_W-1:0]   scan_q, push_q, qidx;
  logic [QP_W-1:0]  head_cur;
  logic [QF_W-1:0]  fill_cur;
  logic             q_full, task_ready;
  logic             in_fire;

  assign in_tready  = (state_r == dats_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_full[g] = &(used_r[g*GS +: GS] | ((g == 0) ? GS'(1) : GS'(0)));
    end
    grp_sel = '0;
    grp_any = 1'b0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        grp_sel = GRP_W'(g);
        grp_any = 1'b1;
      end
    end
  end

  // Id 0 is reserved, so it reads as taken.
  always_comb begin
    grp_bits = used_r[grp_r*GS +: GS] | ((grp_r == '0) ? GS'(1) : GS'(0));
    bit_sel  = '0;
    bit_any  = 1'b0;
    for (int b = GS - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bit_sel = GB_W'(b);
        bit_any = 1'b1;
      end
    end
  end

  // Steps 0 to PRIO-1 visit the worker's own set, the next PRIO the global set.
  always_comb begin
    if (32'(step_r) < PRIO) begin
      scan_skip = !(32'(wrk_r) < dats_pkg::WORKER_SETS);
      scan_q    = Q_W'(PRIO * (32'(wrk_r) + 1) + 32'(step_r));
    end else begin
      scan_skip = 1'b0;
      scan_q    = Q_W'(32'(step_r) - PRIO);
    end
  end

  assign push_q   = dats_pkg::queue_of(attr_q.pri, attr_q.aff);
  assign qidx     = (state_r == dats_pkg::S_QSEL) ? scan_q : push_q;
  assign head_cur = head_r[qidx];
  assign fill_cur = fill_r[qidx];
  assign q_full   = (32'(fill_cur) == dats_pkg::QUEUE_DEPTH);
  assign task_ready = (jc_q == JC_W'(1)) && !((attr_q.dep != '0) && used_r[attr_q.dep]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dats_pkg::S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            dats_pkg::CMD_BEGIN: state_nxt = dats_pkg::S_FGRP;
            dats_pkg::CMD_END, dats_pkg::CMD_DONE:
              state_nxt = used_r[in_tdata[7:0]] ? dats_pkg::S_RDT : dats_pkg::S_OUT;
            dats_pkg::CMD_REQ: state_nxt = dats_pkg::S_QSEL;
            default:           state_nxt = dats_pkg::S_OUT;
          endcase
        end
      end
      dats_pkg::S_FGRP: state_nxt = dats_pkg::S_FBIT;
      dats_pkg::S_FBIT: begin
        if (grp_any && bit_any && par_r != '0) begin
          state_nxt = dats_pkg::S_BPRD;
        end else begin
          state_nxt = dats_pkg::S_OUT;
        end
      end
      dats_pkg::S_BPRD: state_nxt = dats_pkg::S_BPWR;
      dats_pkg::S_BPWR: state_nxt = dats_pkg::S_OUT;
      dats_pkg::S_RDT: begin
        state_nxt = (cmd_r == dats_pkg::CMD_END) ? dats_pkg::S_ENDU : dats_pkg::S_DONEP;
      end
      dats_pkg::S_ENDU: state_nxt = dats_pkg::S_OUT;
      dats_pkg::S_DONEP: begin
        state_nxt = (attr_q.par != '0) ? dats_pkg::S_DNRD : dats_pkg::S_OUT;
      end
      dats_pkg::S_DNRD: state_nxt = dats_pkg::S_DNWR;
      dats_pkg::S_DNWR: state_nxt = dats_pkg::S_OUT;
      dats_pkg::S_QSEL: begin
        if (32'(step_r) == 2 * PRIO) begin
          state_nxt = dats_pkg::S_OUT;
        end else if (!scan_skip && fill_cur != '0) begin
          state_nxt = dats_pkg::S_QPOP;
        end
      end
      dats_pkg::S_QPOP: begin
        state_nxt = used_r[st_q] ? dats_pkg::S_QCHK : dats_pkg::S_QSEL;
      end
      dats_pkg::S_QCHK: begin
        state_nxt = task_ready ? dats_pkg::S_OUT : dats_pkg::S_QSEL;
      end
      dats_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = dats_pkg::S_IDLE;
        end
      end
      default: state_nxt = dats_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cmd_nxt = cmd_r; ref_nxt = ref_r; pri_nxt = pri_r; dep_nxt = dep_r;
    par_nxt = par_r; aff_nxt = aff_r; wrk_nxt = wrk_r;
    used_nxt = used_r; cnt_nxt = cnt_r; grp_nxt = grp_r; id_nxt = id_r;
    step_nxt = step_r; rid_nxt = rid_r; done_nxt = done_r; stat_nxt = stat_r;
    jc_we = 1'b0; jc_waddr = ref_r; jc_wdata = jc_q;
    jc_re = 1'b0; jc_raddr = ref_r;
    attr_we = 1'b0; attr_waddr = id_r;
    attr_wdata = '{dep: dep_r, par: par_r, pri: pri_r, aff: aff_r};
    attr_re = 1'b0; attr_raddr = ref_r;
    st_we = 1'b0; st_wdata = id_r;
    st_waddr = {push_q, QP_W'(head_cur + fill_cur[QP_W-1:0])};
    st_re = 1'b0; st_raddr = {scan_q, head_cur};
    head_we = 1'b0; head_wdata = QP_W'(head_cur + QP_W'(1));
    fill_we = 1'b0; fill_wdata = fill_cur;

    unique case (state_r)
      dats_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = in_tuser;
          ref_nxt  = in_tdata[7:0];
          pri_nxt  = dats_pkg::sat_pri(in_tdata[9:8]);
          dep_nxt  = in_tdata[17:10];
          par_nxt  = in_tdata[25:18];
          aff_nxt  = in_tdata[28:26];
          wrk_nxt  = in_tdata[30:29];
          step_nxt = '0;
          rid_nxt  = '0;
          stat_nxt = dats_pkg::ST_OK;
          done_nxt = (in_tuser == dats_pkg::CMD_QUERY) && !used_r[in_tdata[7:0]];
        end
      end
      dats_pkg::S_FGRP: grp_nxt = grp_sel;
      dats_pkg::S_FBIT: begin
        if (grp_any && bit_any) begin
          id_nxt     = {grp_r, bit_sel};
          attr_we    = 1'b1;
          attr_waddr = {grp_r, bit_sel};
          jc_we      = 1'b1;
          jc_waddr   = {grp_r, bit_sel};
          jc_wdata   = JC_W'(2);
          used_nxt[{grp_r, bit_sel}] = 1'b1;
          cnt_nxt    = cnt_r + ID_W'(1);
          rid_nxt    = {grp_r, bit_sel};
        end else begin
          stat_nxt = dats_pkg::ST_OVERFLOW;
        end
      end
      dats_pkg::S_BPRD: begin
        jc_re    = 1'b1;
        jc_raddr = par_r;
      end
      dats_pkg::S_BPWR: begin
        jc_we    = 1'b1;
        jc_waddr = par_r;
        jc_wdata = jc_q + JC_W'(1);
      end
      dats_pkg::S_RDT: begin
        jc_re   = 1'b1;
        attr_re = 1'b1;
      end
      dats_pkg::S_ENDU: begin
        jc_we    = 1'b1;
        jc_wdata = jc_q - JC_W'(1);
        st_wdata = ref_r;
        if (q_full) begin
          stat_nxt = dats_pkg::ST_QFULL;
        end else begin
          st_we      = 1'b1;
          fill_we    = 1'b1;
          fill_wdata = fill_cur + QF_W'(1);
        end
      end
      dats_pkg::S_DONEP: begin
        used_nxt[ref_r] = 1'b0;
        cnt_nxt         = cnt_r - ID_W'(1);
      end
      dats_pkg::S_DNRD: begin
        jc_re    = 1'b1;
        jc_raddr = attr_q.par;
      end
      dats_pkg::S_DNWR: begin
        jc_we    = 1'b1;
        jc_waddr = attr_q.par;
        jc_wdata = jc_q - JC_W'(1);
      end
      dats_pkg::S_QSEL: begin
        if (32'(step_r) != 2 * PRIO) begin
          if (scan_skip || fill_cur == '0) begin
            step_nxt = step_r + STEP_W'(1);
          end else begin
            st_re      = 1'b1;
            head_we    = 1'b1;
            fill_we    = 1'b1;
            fill_wdata = fill_cur - QF_W'(1);
          end
        end
      end
      dats_pkg::S_QPOP: begin
        id_nxt = st_q;
        if (used_r[st_q]) begin
          jc_re      = 1'b1;
          jc_raddr   = st_q;
          attr_re    = 1'b1;
          attr_raddr = st_q;
        end else begin
          // A head whose task has been freed is dropped.
          step_nxt = step_r + STEP_W'(1);
        end
      end
      dats_pkg::S_QCHK: begin
        if (task_ready) begin
          rid_nxt = id_r;
        end else begin
          step_nxt = step_r + STEP_W'(1);
          if (!q_full) begin
            st_we      = 1'b1;
            fill_we    = 1'b1;
            fill_wdata = fill_cur + QF_W'(1);
          end
        end
      end
      dats_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dats_pkg::S_IDLE;
      used_r       <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        head_r[q] <= '0;
        fill_r[q] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      if (head_we) begin
        head_r[qidx] <= head_wdata;
      end
      if (fill_we) begin
        fill_r[qidx] <= fill_wdata;
      end
      if (state_r == dats_pkg::S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; ref_r <= ref_nxt; pri_r <= pri_nxt; dep_r <= dep_nxt;
    par_r <= par_nxt; aff_r <= aff_nxt; wrk_r <= wrk_nxt;
    grp_r <= grp_nxt; id_r <= id_nxt; step_r <= step_nxt;
    rid_r <= rid_nxt; done_r <= done_nxt; stat_r <= stat_nxt;
    if (state_r == dats_pkg::S_OUT && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {5'b0, cnt_r, stat_r, done_r, rid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (jc_we) begin
      jc_mem[jc_waddr] <= jc_wdata;
    end
    if (jc_re) begin
      jc_q <= jc_mem[jc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[attr_waddr] <= attr_wdata;
    end
    if (attr_re) begin
      attr_q <= attr_mem[attr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_q <= st_mem[st_raddr];
    end
  end

  // The open count always equals the number of ids in use.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(used_r))
    else $error("open count differs from ids in use");

  a_id0_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    !used_r[0])
    else $error("id 0 was allocated");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != dats_pkg::S_IDLE)
    else $error("sequencer idle right after accepting a transaction");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(step_r) <= 2 * PRIO || state_r != dats_pkg::S_QSEL)
    else $error("request scan ran past the last FIFO");

  a_dispatch_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dats_pkg::S_QCHK && task_ready) |=> rid_r != '0)
    else $error("dispatched id is zero");

endmodule

>>> dv/dependency_aware_task_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler testbench
// Streams begin, end, request, done and query commands into the scheduler.
// A scoreboard keeps its own copy of the task pool and the FIFOs and compares
// every result transaction with the predicted one.
// ----------------------------------------------------------------------------
module dependency_aware_task_scheduler_unit_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  // Packed from the highest bit down, so rid lands in the lowest byte.
  typedef struct packed {
    logic [7:0] open;
    logic [1:0] status;
    logic       done;
    logic [7:0] rid;
  } sched_result_t;

  // Model of the scheduler state.
  logic [dats_pkg::TASKS-1:0] m_used;
  logic [8:0]       m_jobs [dats_pkg::TASKS];
  logic [7:0]       m_dep  [dats_pkg::TASKS];
  logic [7:0]       m_par  [dats_pkg::TASKS];
  logic [1:0]       m_pri  [dats_pkg::TASKS];
  logic [2:0]       m_aff  [dats_pkg::TASKS];
  logic [7:0]       m_fifo [dats_pkg::NUM_QUEUES][$];
  logic [7:0]       m_open;

  sched_result_t expected_results [$];
  int  errors;
  int  n_sent;
  int  n_checked;
  int  n_dispatched;
  int  n_overflow;
  int  n_qfull;
  bit  long_hold;
  bit  no_idle;

  dependency_aware_task_scheduler_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int fifo_index(input logic [7:0] id);
    int p;
    p = (m_pri[id] >= dats_pkg::PRIORITIES) ? dats_pkg::PRIORITIES - 1 : m_pri[id];
    if (m_aff[id] == 0 || m_aff[id] > dats_pkg::WORKER_SETS) return p;
    return dats_pkg::PRIORITIES * m_aff[id] + p;
  endfunction

  function automatic void fifo_append(input int q, input logic [7:0] id);
    m_fifo[q] = {m_fifo[q], id};
  endfunction

  // Pops one head; returns the id if it may run, else rotates it or drops it.
  function automatic logic [7:0] visit_fifo(input int q);
    logic [7:0] id;
    int         dst;
    if (m_fifo[q].size() == 0) return 8'd0;
    id = m_fifo[q].pop_front();
    if (!m_used[id]) return 8'd0;
    if (m_jobs[id] == 9'd1 && !(m_dep[id] != 0 && m_used[m_dep[id]])) return id;
    dst = fifo_index(id);
    if (m_fifo[dst].size() < dats_pkg::QUEUE_DEPTH) fifo_append(dst, id);
    return 8'd0;
  endfunction

  function automatic sched_result_t schedule_step(input logic [2:0] cmd,
                                                  input logic [31:0] d);
    sched_result_t r;
    logic [7:0] ref_id, dep, par, id;
    logic [1:0] pri, wrk;
    logic [2:0] aff;
    r = '0;
    ref_id = d[7:0];
    pri = d[9:8];
    dep = d[17:10];
    par = d[25:18];
    aff = d[28:26];
    wrk = d[30:29];
    unique case (cmd)
      dats_pkg::CMD_BEGIN: begin
        id = 0;
        for (int i = 1; i < dats_pkg::TASKS; i++) begin
          if (!m_used[i] && id == 0) id = 8'(i);
        end
        if (id == 0) begin
          r.status = dats_pkg::ST_OVERFLOW;
        end else begin
          m_used[id] = 1'b1;
          m_pri[id] = (pri >= dats_pkg::PRIORITIES) ? 2'(dats_pkg::PRIORITIES - 1) : pri;
          m_dep[id] = dep;
          m_par[id] = par;
          m_aff[id] = aff;
          m_jobs[id] = 9'd2;
          if (par != 0) m_jobs[par] = m_jobs[par] + 9'd1;
          m_open = m_open + 8'd1;
          r.rid = id;
        end
      end
      dats_pkg::CMD_END: begin
        if (m_used[ref_id]) begin
          m_jobs[ref_id] = m_jobs[ref_id] - 9'd1;
          if (m_fifo[fifo_index(ref_id)].size() >= dats_pkg::QUEUE_DEPTH)
            r.status = dats_pkg::ST_QFULL;
          else fifo_append(fifo_index(ref_id), ref_id);
        end
      end
      dats_pkg::CMD_REQ: begin
        if (wrk < dats_pkg::WORKER_SETS) begin
          for (int i = 0; i < dats_pkg::PRIORITIES; i++) begin
            if (r.rid == 0) r.rid = visit_fifo(dats_pkg::PRIORITIES * (wrk + 1) + i);
          end
        end
        for (int i = 0; i < dats_pkg::PRIORITIES; i++) begin
          if (r.rid == 0) r.rid = visit_fifo(i);
        end
      end
      dats_pkg::CMD_DONE: begin
        if (m_used[ref_id]) begin
          if (m_par[ref_id] != 0) m_jobs[m_par[ref_id]] = m_jobs[m_par[ref_id]] - 9'd1;
          m_used[ref_id] = 1'b0;
          m_open = m_open - 8'd1;
        end
      end
      dats_pkg::CMD_QUERY: r.done = !m_used[ref_id];
      default: ;
    endcase
    r.open = m_open;
    return r;
  endfunction

  // Leaves in_tvalid high on return; a later idle gap or the end of the run drops it.
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] ref_id,
                              input logic [1:0] pri, input logic [7:0] dep,
                              input logic [7:0] par, input logic [2:0] aff,
                              input logic [1:0] wrk);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, wrk, aff, par, dep, pri, ref_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results = {expected_results,
                        schedule_step(cmd, {1'b0, wrk, aff, par, dep, pri, ref_id})};
    n_sent++;
  endtask

  // Picks a parent or dependency that is live, or none; never an unwritten id.
  function automatic logic [7:0] pick_live();
    logic [7:0] c;
    c = $urandom_range(1, 80);
    if ($urandom_range(0, 2) == 0 || !m_used[c]) return 8'd0;
    return c;
  endfunction

  function automatic logic [7:0] pick_ref();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 80));
  endfunction

  task automatic random_command();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25)
      send_command(dats_pkg::CMD_BEGIN, 8'($urandom), 2'($urandom), pick_live(),
                   pick_live(), 3'($urandom_range(0, 5)), 2'($urandom));
    else if (sel < 50)
      send_command(dats_pkg::CMD_END, pick_ref(), 2'($urandom), 8'($urandom),
                   8'($urandom), 3'($urandom), 2'($urandom));
    else if (sel < 72)
      send_command(dats_pkg::CMD_REQ, 8'($urandom), 2'($urandom), 8'($urandom),
                   8'($urandom), 3'($urandom), 2'($urandom));
    else if (sel < 90)
      send_command(dats_pkg::CMD_DONE, pick_ref(), 2'($urandom), 8'($urandom),
                   8'($urandom), 3'($urandom), 2'($urandom));
    else if (sel < 97)
      send_command(dats_pkg::CMD_QUERY, 8'($urandom), 2'($urandom), 8'($urandom),
                   8'($urandom), 3'($urandom), 2'($urandom));
    else
      send_command(3'($urandom_range(5, 7)), 8'($urandom), 2'($urandom), 8'($urandom),
                   8'($urandom), 3'($urandom), 2'($urandom));
  endtask

  task automatic test_directed();
    send_command(dats_pkg::CMD_QUERY, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_BEGIN, 8'hff, 2'd3, 8'd0, 8'd0, 3'd0, 2'd3);
    send_command(dats_pkg::CMD_BEGIN, 8'd0, 2'd0, 8'd1, 8'd1, 3'd7, 2'd0);
    send_command(dats_pkg::CMD_BEGIN, 8'd0, 2'd1, 8'd0, 8'd1, 3'd4, 2'd0);
    send_command(dats_pkg::CMD_END, 8'd2, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_END, 8'd3, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_END, 8'd1, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_REQ, 8'd0, 2'd0, 8'hff, 8'hff, 3'd7, 2'd3);
    send_command(dats_pkg::CMD_REQ, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_DONE, 8'd3, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_REQ, 8'hff, 2'd3, 8'd0, 8'd0, 3'd0, 2'd3);
    send_command(dats_pkg::CMD_DONE, 8'd2, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_REQ, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'd1);
    send_command(dats_pkg::CMD_END, 8'hff, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_DONE, 8'd200, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_QUERY, 8'd1, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(dats_pkg::CMD_QUERY, 8'hff, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    send_command(3'd5, 8'hff, 2'd3, 8'hff, 8'hff, 3'd7, 2'd3);
    send_command(3'd7, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
  endtask

  // Fills the pool to overflow, overfills one FIFO, then frees every task.
  task automatic test_pool_and_queue_full();
    no_idle = 1'b1;
    for (int i = 0; i < 258; i++)
      send_command(dats_pkg::CMD_BEGIN, 8'd0, 2'd0, 8'd0, 8'd0, 3'd2, 2'd0);
    for (int i = 1; i <= 70; i++)
      send_command(dats_pkg::CMD_END, 8'(i), 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    for (int i = 0; i < 8; i++)
      send_command(dats_pkg::CMD_REQ, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'd1);
    for (int i = 1; i < 256; i++)
      send_command(dats_pkg::CMD_DONE, 8'(i), 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
    for (int i = 0; i < 4; i++)
      send_command(dats_pkg::CMD_REQ, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'($urandom));
    no_idle = 1'b0;
  endtask

  // The receiver process clears long_hold once its long stall is over.
  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (12) random_command();
  endtask

  // Mostly task lifetimes: begin, then at random an end, a request and a done.
  task automatic test_random();
    logic [7:0] id;
    for (int n = 0; n < 900; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        random_command();
      end else begin
        send_command(dats_pkg::CMD_BEGIN, 8'd0, 2'($urandom), pick_live(), pick_live(),
                     3'($urandom_range(0, 5)), 2'($urandom));
        id = expected_results[$].rid;
        if (id != 0 && $urandom_range(0, 1) == 0)
          send_command(dats_pkg::CMD_END, id, 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
        if ($urandom_range(0, 1) == 0)
          send_command(dats_pkg::CMD_REQ, 8'd0, 2'd0, 8'd0, 8'd0, 3'd0, 2'($urandom));
        if ($urandom_range(0, 2) == 0)
          send_command(dats_pkg::CMD_DONE, pick_ref(), 2'd0, 8'd0, 8'd0, 3'd0, 2'd0);
      end
      if (n_sent >= 1350) break;
    end
  endtask

  initial begin
    int gap;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sched_result_t exp_r, act_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r = sched_result_t'(out_tdata[18:0]);
      n_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.rid != 0 && exp_r.status == dats_pkg::ST_OK) n_dispatched++;
        if (exp_r.status == dats_pkg::ST_OVERFLOW) n_overflow++;
        if (exp_r.status == dats_pkg::ST_QFULL) n_qfull++;
        if (act_r !== exp_r) begin
          $display("%0t: mismatch expected id %0d done %0d st %0d open %0d,",
                   $time, exp_r.rid, exp_r.done, exp_r.status, exp_r.open);
          $display("%0t:          actual id %0d done %0d st %0d open %0d",
                   $time, act_r.rid, act_r.done, act_r.status, act_r.open);
          errors++;
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_dispatched = 0;
    n_overflow = 0;
    n_qfull = 0;
    long_hold = 1'b0;
    no_idle = 1'b0;
    m_used = '0;
    m_open = '0;
    for (int i = 0; i < dats_pkg::TASKS; i++) begin
      m_jobs[i] = '0;
      m_dep[i] = '0;
      m_par[i] = '0;
      m_pri[i] = '0;
      m_aff[i] = '0;
    end
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_and_queue_full();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d commands, checked %0d results: %0d with ids, %0d overflow, %0d full.",
             n_sent, n_checked, n_dispatched, n_overflow, n_qfull);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
